// ===== design/dog_pkg.sv =====
package dog_pkg;

  localparam int MaxWidth   = 1024;
  localparam int SampleBits = 16;
  localparam int RowLimit   = 1024;
  localparam int ColBits    = 10;
  localparam int WordBits   = 4 * SampleBits;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMargin = 2'd2;
  localparam logic [1:0] RegRatio  = 2'd3;

  typedef logic [WordBits-1:0] word_t;
  typedef logic signed [SampleBits-1:0] dog_t;
  typedef logic [SampleBits-1:0] gauss_t;

  // window handed from the front end to the test datapath
  typedef struct packed {
    logic           valid;
    logic [ColBits-1:0] cx;
    logic [ColBits-1:0] cy;
    word_t [2:0][2:0] win;
  } cand_t;

endpackage

// ===== design/dog_test.sv =====
// Extremum and Hessian edge tests over one 3x3 window, pipelined.
module dog_test (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  dog_pkg::cand_t        cand,
  input  logic [4:0]            ratio,
  output logic                  out_valid,
  output logic [9:0]            out_cx,
  output logic [9:0]            out_cy,
  output logic                  out_ext,
  output logic                  out_edge
);
  import dog_pkg::*;

  // stage 1 results
  logic                s1_valid;
  logic [ColBits-1:0]  s1_cx, s1_cy;
  logic                s1_ext;
  logic signed [19:0]  s1_dxx, s1_dyy, s1_dxy4;
  // stage 2 results
  logic                s2_valid;
  logic [ColBits-1:0]  s2_cx, s2_cy;
  logic                s2_ext;
  logic signed [41:0]  s2_det4;
  logic signed [41:0]  s2_tr2;
  // stage 3 results
  logic                s3_valid;
  logic [ColBits-1:0]  s3_cx, s3_cy;
  logic                s3_ext;
  logic                s3_pos;
  logic signed [51:0]  s3_lhs, s3_rhs;

  logic                ext_c;
  logic signed [19:0]  g [3][3];
  logic signed [20:0]  tr_c;
  logic [5:0]          r1;

  // compare centre against its 26 neighbors
  always_comb begin
    logic signed [SampleBits-1:0] dv;
    logic signed [SampleBits-1:0] nb;
    logic above, below;
    dv = cand.win[1][1][2*SampleBits-1:SampleBits];
    above = 1'b0;
    below = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          nb = cand.win[r][c][k*SampleBits +: SampleBits];
          if (!(k == 1 && r == 1 && c == 1)) begin
            if (dv > nb) above = 1'b1;
            if (dv < nb) below = 1'b1;
          end
        end
      end
    end
    ext_c = !above || !below;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        g[i][j] = signed'({4'd0, cand.win[i][j][3*SampleBits +: SampleBits]});
  end

  assign tr_c = 21'(s1_dxx) + 21'(s1_dyy);
  assign r1   = 6'(ratio) + 6'd1;

  // advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cand.valid;
      s1_cx <= cand.cx;
      s1_cy <= cand.cy;
      s1_ext <= ext_c;
      s1_dxx <= g[1][0] - (g[1][1] <<< 1) + g[1][2];
      s1_dyy <= g[0][1] - (g[1][1] <<< 1) + g[2][1];
      s1_dxy4 <= g[2][2] - g[2][0] - g[0][2] + g[0][0];

      s2_valid <= s1_valid;
      s2_cx <= s1_cx;
      s2_cy <= s1_cy;
      s2_ext <= s1_ext;
      s2_det4 <= ((42'(s1_dxx) * 42'(s1_dyy)) <<< 4) - 42'(s1_dxy4) * 42'(s1_dxy4);
      s2_tr2 <= 42'(tr_c) * 42'(tr_c);

      s3_valid <= s2_valid;
      s3_cx <= s2_cx;
      s3_cy <= s2_cy;
      s3_ext <= s2_ext;
      s3_pos <= s2_det4 > 42'sd0;
      s3_lhs <= 52'(s2_tr2) * signed'({47'd0, ratio}) <<< 4;
      s3_rhs <= 52'(s2_det4) * signed'({40'd0, 12'(r1) * 12'(r1)});

      out_valid <= s3_valid;
      out_cx <= s3_cx;
      out_cy <= s3_cy;
      out_ext <= s3_ext;
      out_edge <= s3_pos && (s3_lhs < s3_rhs);
    end
  end

endmodule

// ===== design/dog_extremum_edge_test.sv =====
// DoG keypoint detector, one pixel word per clock in raster order.
// Input channel: valid/stall with prev_dog, cur_dog, next_dog, cur_gauss.
// Output channel: valid/stall with center_x, center_y and the three flags;
// a result is given for each window centre inside the border margin.
// Config channel: cfg_valid/cfg_ready, cfg_index selects width, height,
// margin, ratio; write only while idle.
// Throughput: one pixel per cycle unless stalled. Two line stores share one
// synchronous memory (row above and row two above packed in one entry); the
// read of column x is issued at acceptance and used when stage A advances, so
// it is a two-stage read-modify-write with forwarding when consecutive pixels
// hit the same column (width of one).
// Path: stage A, the window registers and the dog_test stages lie between the
// acceptance of the window's last pixel and its result word. The whole pipeline
// halts while the output stalls; in_stall is out_valid and out_stall combined,
// so it rises in the same cycle as a stalled result.
// Reset clears counters, the window and the pipeline; line stores are not
// cleared, and config returns to 640x480, margin 17, ratio 10.
module dog_extremum_edge_test (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dog_pkg::dog_t          prev_dog,
  input  dog_pkg::dog_t          cur_dog,
  input  dog_pkg::dog_t          next_dog,
  input  dog_pkg::gauss_t        cur_gauss,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [9:0]             center_x,
  output logic [9:0]             center_y,
  output logic                   is_extremum,
  output logic                   passes_edge,
  output logic                   is_keypoint,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [10:0]            cfg_data
);
  import dog_pkg::*;

  logic [10:0] image_width, image_height;
  logic [4:0]  border_margin, edge_ratio;
  logic [ColBits-1:0] column_count, row_count;

  logic [2*WordBits-1:0] line_mem [MaxWidth];
  logic [2*WordBits-1:0] line_mem_q;
  logic [2*WordBits-1:0] fwd_word;
  logic [2*WordBits-1:0] fwd_word_prev;
  logic                  fwd_hit;

  word_t [2:0][2:0] window_regs;

  // stage A: accepted pixel awaiting memory data
  logic               a_valid;
  word_t              a_packed;
  logic [ColBits-1:0] a_x;
  logic               a_chk;
  logic [ColBits-1:0] a_cx, a_cy;

  logic               cand_valid;
  logic [ColBits-1:0] cand_cx, cand_cy;
  cand_t cand;
  logic  en, acc, t_valid, t_ext, t_edge;
  logic [9:0] t_cx, t_cy;

  logic [11:0] w_use, h_use;
  logic [4:0]  m_use;
  logic [ColBits:0] x_eff, y_eff, x_nx, y_nx;
  logic [ColBits-1:0] cx_c, cy_c;
  logic in_win;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign acc       = in_valid && en;
  assign cfg_ready = 1'b1;

  // clamp config and locate the pixel
  always_comb begin
    w_use = (image_width == 11'd0) ? 12'd1 :
            (image_width > 11'(MaxWidth)) ? 12'(MaxWidth) : 12'(image_width);
    h_use = (image_height == 11'd0) ? 12'd1 :
            (image_height > 11'(RowLimit)) ? 12'(RowLimit) : 12'(image_height);
    m_use = (border_margin == 5'd0) ? 5'd1 : border_margin;
    x_eff = 11'(column_count);
    y_eff = 11'(row_count);
    if (12'(x_eff) >= w_use) begin
      x_eff = '0;
      y_eff = y_eff + 11'd1;
    end
    if (12'(y_eff) >= h_use) y_eff = '0;
    cx_c = ColBits'(x_eff - 11'd1);
    cy_c = ColBits'(y_eff - 11'd1);
    in_win = (x_eff != '0) && (y_eff != '0)
           && (12'(cx_c) >= 12'(m_use)) && (12'(cy_c) >= 12'(m_use))
           && (12'(cx_c) + 12'(m_use) < w_use) && (12'(cy_c) + 12'(m_use) < h_use);
    x_nx = x_eff + 11'd1;
    y_nx = y_eff;
    if (12'(x_nx) >= w_use) begin
      x_nx = '0;
      y_nx = y_eff + 11'd1;
      if (12'(y_nx) >= h_use) y_nx = '0;
    end
  end

  // config writes, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd640;
      image_height <= 11'd480;
      border_margin <= 5'd17;
      edge_ratio <= 5'd10;
      column_count <= '0;
      row_count <= '0;
      a_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegWidth:  image_width <= cfg_data;
          RegHeight: image_height <= cfg_data;
          RegMargin: border_margin <= cfg_data[4:0];
          RegRatio:  edge_ratio <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (en) begin
        a_valid <= acc;
        if (acc) begin
          column_count <= ColBits'(x_nx);
          row_count <= ColBits'(y_nx);
        end
      end
    end
  end

  // write back stage A, read the line memory at acceptance
  always_ff @(posedge clk) begin
    if (en && a_valid) line_mem[a_x] <= {fwd_word[WordBits-1:0], a_packed};
    if (acc) begin
      line_mem_q <= line_mem[ColBits'(x_eff)];
      fwd_hit <= a_valid && (a_x == ColBits'(x_eff));
      a_packed <= {cur_gauss, next_dog, cur_dog, prev_dog};
      a_x <= ColBits'(x_eff);
      a_chk <= in_win;
      a_cx <= cx_c;
      a_cy <= cy_c;
    end
  end

  // effective {row two above, row above}; forwarded on back-to-back same column
  always_comb fwd_word = fwd_hit ? fwd_word_prev : line_mem_q;

  // shift window, emit candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
      cand_valid <= 1'b0;
    end else if (en) begin
      cand_valid <= 1'b0;
      if (a_valid) begin
        fwd_word_prev <= {fwd_word[WordBits-1:0], a_packed};
        for (int r = 0; r < 3; r++) begin
          window_regs[r][0] <= window_regs[r][1];
          window_regs[r][1] <= window_regs[r][2];
        end
        window_regs[0][2] <= fwd_word[2*WordBits-1:WordBits];
        window_regs[1][2] <= fwd_word[WordBits-1:0];
        window_regs[2][2] <= a_packed;
        cand_valid <= a_chk;
        cand_cx <= a_cx;
        cand_cy <= a_cy;
      end
    end
  end
  assign cand = {cand_valid, cand_cx, cand_cy, window_regs};

  dog_test u_test (
    .clk(clk), .rst(rst), .en(en), .cand(cand), .ratio(edge_ratio),
    .out_valid(t_valid), .out_cx(t_cx), .out_cy(t_cy),
    .out_ext(t_ext), .out_edge(t_edge)
  );

  assign out_valid   = t_valid;
  assign center_x    = t_cx;
  assign center_y    = t_cy;
  assign is_extremum = t_ext;
  assign passes_edge = t_edge;
  assign is_keypoint = t_ext && t_edge;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import dog_pkg::*;

  typedef struct {
    logic [9:0] cx;
    logic [9:0] cy;
    logic       ext;
    logic       edge_ok;
    logic       key;
  } keypoint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  dog_t prev_dog = '0;
  dog_t cur_dog = '0;
  dog_t next_dog = '0;
  gauss_t cur_gauss = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] center_x;
  logic [9:0] center_y;
  logic is_extremum;
  logic passes_edge;
  logic is_keypoint;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // predictor state
  word_t above_row [MaxWidth];
  word_t above2_row [MaxWidth];
  word_t win [3][3];
  int unsigned col_cnt, row_cnt;
  int unsigned reg_width, reg_height, reg_margin, reg_ratio;

  keypoint_t pending_points[$];
  int errors = 0;
  int words_sent = 0;
  int points_seen = 0;
  int keypoints_seen = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  dog_extremum_edge_test u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .prev_dog(prev_dog), .cur_dog(cur_dog), .next_dog(next_dog),
    .cur_gauss(cur_gauss),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_x(center_x), .center_y(center_y),
    .is_extremum(is_extremum), .passes_edge(passes_edge),
    .is_keypoint(is_keypoint),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint lane_s(word_t wd, int k);
    logic signed [15:0] v;
    v = wd[k*16 +: 16];
    return longint'(v);
  endfunction

  function automatic bit window_extremum();
    longint ctr, nb;
    int up, dn;
    ctr = lane_s(win[1][1], 1);
    up = 0;
    dn = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 3; k++) begin
          if (!(k == 1 && r == 1 && c == 1)) begin
            nb = lane_s(win[r][c], k);
            if (ctr > nb) up++;
            if (ctr < nb) dn++;
          end
        end
    return (up == 0) || (dn == 0);
  endfunction

  function automatic bit hessian_ok();
    longint g [3][3];
    longint dxx, dyy, dxy4, tr, det4, r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        g[i][j] = longint'({1'b0, win[i][j][63:48]});
    dxx = g[1][0] - 2 * g[1][1] + g[1][2];
    dyy = g[0][1] - 2 * g[1][1] + g[2][1];
    dxy4 = g[2][2] - g[2][0] - g[0][2] + g[0][0];
    tr = dxx + dyy;
    det4 = 16 * dxx * dyy - dxy4 * dxy4;
    if (det4 <= 0) return 1'b0;
    r = longint'(reg_ratio);
    return 16 * r * tr * tr < (r + 1) * (r + 1) * det4;
  endfunction

  // advance the pixel model by one word, queue the keypoint record if any
  function automatic void predict_pixel(dog_t p, dog_t c, dog_t n, gauss_t g);
    int unsigned w, h, m, x, y, cx, cy;
    word_t pk;
    keypoint_t kp;
    w = reg_width;
    h = reg_height;
    m = reg_margin;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h < 1) h = 1;
    if (h > RowLimit) h = RowLimit;
    if (m < 1) m = 1;
    x = col_cnt;
    y = row_cnt;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    pk = {g, n, c, p};
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2_row[x];
    win[1][2] = above_row[x];
    win[2][2] = pk;
    above2_row[x] = above_row[x];
    above_row[x] = pk;
    if (x >= 1 && y >= 1) begin
      cx = x - 1;
      cy = y - 1;
      if (cx >= m && cy >= m && cx + m < w && cy + m < h) begin
        kp.cx = cx[9:0];
        kp.cy = cy[9:0];
        kp.ext = window_extremum();
        kp.edge_ok = hessian_ok();
        kp.key = kp.ext & kp.edge_ok;
        pending_points = {pending_points, kp};
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_cnt = x;
    row_cnt = y;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // check each accepted result word against the oldest prediction
  initial begin
    keypoint_t kp;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected result word, x", center_x, -1);
        end else begin
          kp = pending_points.pop_front();
          points_seen++;
          if (kp.key) keypoints_seen++;
          if (center_x !== kp.cx) report_mismatch("center_x", center_x, kp.cx);
          if (center_y !== kp.cy) report_mismatch("center_y", center_y, kp.cy);
          if (is_extremum !== kp.ext) report_mismatch("is_extremum", is_extremum, kp.ext);
          if (passes_edge !== kp.edge_ok)
            report_mismatch("passes_edge", passes_edge, kp.edge_ok);
          if (is_keypoint !== kp.key) report_mismatch("is_keypoint", is_keypoint, kp.key);
        end
      end
    end
  end

  // drive the receiver stall: random, quiet, or one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  task automatic send_pixel(dog_t p, dog_t c, dog_t n, gauss_t g);
    bit took;
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    prev_dog <= p;
    cur_dog <= c;
    next_dog <= n;
    cur_gauss <= g;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    predict_pixel(p, c, n, g);
    words_sent++;
  endtask

  task automatic stop_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results, then let the pipeline empty
  task automatic wait_idle();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    case (idx)
      RegWidth:  reg_width = val;
      RegHeight: reg_height = val;
      RegMargin: reg_margin = val[4:0];
      RegRatio:  reg_ratio = val[4:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int m, int r);
    write_reg(RegWidth, w[10:0]);
    write_reg(RegHeight, h[10:0]);
    write_reg(RegMargin, m[10:0]);
    write_reg(RegRatio, r[10:0]);
  endtask

  // mix full-range noise with narrow and flat samples so ties and peaks occur
  task automatic send_random(int count);
    int mode;
    dog_t p, c, n;
    gauss_t g;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      if (mode < 3) begin
        p = 16'($urandom);
        c = 16'($urandom);
        n = 16'($urandom);
        g = 16'($urandom);
      end else if (mode < 7) begin
        p = 16'(int'($urandom_range(4)) - 2);
        c = 16'(int'($urandom_range(4)) - 2);
        n = 16'(int'($urandom_range(4)) - 2);
        g = 16'(1000 + $urandom_range(8));
      end else begin
        p = '0;
        c = ($urandom_range(1)) ? 16'sd0 : 16'sd3;
        n = '0;
        g = ($urandom_range(1)) ? 16'd65535 : 16'd500;
      end
      send_pixel(p, c, n, g);
    end
    stop_stream();
  endtask

  // 5x5 frame: flat rows, sample extremes, gauss peak, margin and ratio zero
  task automatic test_directed();
    dog_t c;
    gauss_t g;
    set_frame(5, 5, 0, 0);
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++) begin
        c = '0;
        g = 16'd100;
        if (y == 2 && x == 2) begin
          c = 16'sh7fff;
          g = 16'hffff;
        end
        if (y == 3 && x == 2) c = 16'sh8000;
        if (y == 4) g = 16'd0;
        if (y < 2) send_pixel('0, '0, '0, '0);
        else if (y == 3 && x == 3) send_pixel(16'sh7fff, c, 16'sh8000, g);
        else send_pixel('0, c, '0, g);
      end
    stop_stream();
    wait_idle();
  endtask

  task automatic test_small_frame();
    set_frame(36, 36, 1, 31);
    send_random(324);
    wait_idle();
  endtask

  // widest border, then shrink height mid-frame so the row count wraps
  task automatic test_border();
    set_frame(36, 40, 17, 10);
    send_random(360);
    wait_idle();
    write_reg(RegHeight, 11'd18);
    write_reg(RegMargin, 11'd2);
    send_random(216);
    wait_idle();
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    set_frame(36, 18, 2, 10);
    hold_req = 1'b1;
    send_random(180);
    wait_idle();
  endtask

  // no idling on either side
  task automatic test_quiet();
    quiet = 1'b1;
    set_frame(36, 18, 1, 1);
    send_random(108);
    wait_idle();
    quiet = 1'b0;
  endtask

  // zero and all-ones register values; width one runs same column back to back
  task automatic test_reg_extremes();
    set_frame(0, 40, 31, 0);
    send_random(20);
    wait_idle();
    set_frame(36, 2047, 1, 31);
    send_random(108);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      above_row[i] = '0;
      above2_row[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_cnt = 0;
    row_cnt = 0;
    reg_width = 640;
    reg_height = 480;
    reg_margin = 17;
    reg_ratio = 10;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_frame();
    test_border();
    test_backpressure();
    test_quiet();
    test_reg_extremes();
    repeat (20) @(posedge clk);
    $display("Sent %0d pixel words over several frame shapes, margins and ratios.",
             words_sent);
    $display("Checked %0d window centres, %0d of them keypoints.",
             points_seen, keypoints_seen);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("dog_extremum_edge_test test passed");
    end else begin
      $display("dog_extremum_edge_test test failed");
    end
    $finish;
  end

  // hard stop on a hung run
  initial begin
    #3000000;
    $display("dog_extremum_edge_test test failed");
    $finish;
  end

endmodule
